/* sv/ptom_pkg.sv */
// Shared types, codes and constants of the price-time order matcher.
package ptom_pkg;

  localparam int DEF_ORDER_SLOTS = 63;
  // At most this many trades for one incoming order; one more result carries its status.
  localparam int MAX_TRADES = 63;
  localparam int TRADE_W = 6;

  localparam logic [1:0] FN_LIMIT  = 2'd0;
  localparam logic [1:0] FN_MARKET = 2'd1;
  localparam logic [1:0] FN_CANCEL = 2'd2;
  localparam logic [1:0] FN_NONE   = 2'd3;

  localparam logic SIDE_BUY  = 1'b0;
  localparam logic SIDE_SELL = 1'b1;

  localparam logic [2:0] KIND_TRADE     = 3'd0;
  localparam logic [2:0] KIND_RESTED    = 3'd1;
  localparam logic [2:0] KIND_FILLED    = 3'd2;
  localparam logic [2:0] KIND_DROPPED   = 3'd3;
  localparam logic [2:0] KIND_CANCELLED = 3'd4;
  localparam logic [2:0] KIND_NOT_FOUND = 3'd5;

  typedef struct packed {
    logic        side;
    logic [31:0] ident;
    logic [19:0] price;
    logic [31:0] remaining;
    logic [31:0] arrival;
  } ptom_entry_t;

  typedef struct packed {
    logic        data_we;
    logic        vld_we;
    logic        vld_val;
  } ptom_wr_t;

  typedef struct packed {
    logic        bid_p;
    logic [19:0] bid;
    logic        ask_p;
    logic [19:0] ask;
    logic        m_p;
    ptom_entry_t m_entry;
    logic        free_p;
    logic        hit_p;
    logic [31:0] hit_rem;
  } ptom_scan_t;

endpackage

/* sv/ptom_ifs.sv */
// Handshake channels for incoming orders and for results.
interface ptom_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  func;
  logic        side;
  logic [31:0] order_id;
  logic [19:0] limit_price;
  logic [31:0] quantity;
  modport source (output valid, func, side, order_id, limit_price, quantity, input ready);
  modport sink   (input valid, func, side, order_id, limit_price, quantity, output ready);
endinterface

interface ptom_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  kind;
  logic [31:0] trade_number;
  logic [31:0] buy_order_id;
  logic [31:0] sell_order_id;
  logic [19:0] trade_price;
  logic [31:0] trade_quantity;
  logic [31:0] remaining_quantity;
  logic [19:0] best_bid;
  logic [19:0] best_ask;
  logic        bid_present;
  logic        ask_present;
  logic        last;
  modport source (output valid, kind, trade_number, buy_order_id, sell_order_id, trade_price,
                  trade_quantity, remaining_quantity, best_bid, best_ask, bid_present,
                  ask_present, last, input ready);
  modport sink   (input valid, kind, trade_number, buy_order_id, sell_order_id, trade_price,
                  trade_quantity, remaining_quantity, best_bid, best_ask, bid_present,
                  ask_present, last, output ready);
endinterface

/* sv/ptom_book.sv */
// Order table: entry memory with one write and one registered read port, plus valid flags.
module ptom_book import ptom_pkg::*; #(
  parameter int ORDER_SLOTS = DEF_ORDER_SLOTS,
  parameter int IDX_W = $clog2(ORDER_SLOTS)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [IDX_W-1:0] rd_idx,
  output ptom_entry_t      rd_entry_r,
  output logic             rd_valid_r,
  input  logic [IDX_W-1:0] wr_idx,
  input  ptom_wr_t         wr,
  input  ptom_entry_t      wr_entry
);

  ptom_entry_t            mem_r [ORDER_SLOTS];
  logic [ORDER_SLOTS-1:0] valid_r;

  always_ff @(posedge clk) begin
    if (wr.data_we) begin
      mem_r[wr_idx] <= wr_entry;
    end
    rd_entry_r <= mem_r[rd_idx];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r    <= '0;
      rd_valid_r <= 1'b0;
    end else begin
      if (wr.vld_we) begin
        valid_r[wr_idx] <= wr.vld_val;
      end
      rd_valid_r <= valid_r[rd_idx];
    end
  end

endmodule

/* sv/ptom_scan.sv */
// Scan unit: folds one table entry per cycle into best prices, best match, free slot and cancel hit.
module ptom_scan import ptom_pkg::*; #(
  parameter int ORDER_SLOTS = DEF_ORDER_SLOTS,
  parameter int IDX_W = $clog2(ORDER_SLOTS)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             clear,
  input  logic             eval,
  input  ptom_entry_t      entry,
  input  logic             entry_valid,
  input  logic [IDX_W-1:0] entry_idx,
  input  logic             opp_side,
  input  logic [31:0]      cancel_id,
  output ptom_scan_t       res_r,
  output logic [IDX_W-1:0] m_idx_r,
  output logic [IDX_W-1:0] free_idx_r,
  output logic [IDX_W-1:0] hit_idx_r
);

  logic [31:0] hit_arr_r;
  logic        take_bid, take_ask, take_m, take_free, take_hit, m_better;

  always_comb begin
    if (entry.price != res_r.m_entry.price) begin
      m_better = (opp_side == SIDE_BUY) ? (entry.price > res_r.m_entry.price)
                                        : (entry.price < res_r.m_entry.price);
    end else begin
      m_better = entry.arrival < res_r.m_entry.arrival;
    end
    take_bid  = eval && entry_valid && (entry.side == SIDE_BUY) &&
                (!res_r.bid_p || entry.price > res_r.bid);
    take_ask  = eval && entry_valid && (entry.side == SIDE_SELL) &&
                (!res_r.ask_p || entry.price < res_r.ask);
    take_m    = eval && entry_valid && (entry.side == opp_side) && (!res_r.m_p || m_better);
    take_free = eval && !entry_valid && !res_r.free_p;
    take_hit  = eval && entry_valid && (entry.ident == cancel_id) &&
                (!res_r.hit_p || entry.arrival < hit_arr_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n || clear) begin
      res_r.bid_p  <= 1'b0;
      res_r.ask_p  <= 1'b0;
      res_r.m_p    <= 1'b0;
      res_r.free_p <= 1'b0;
      res_r.hit_p  <= 1'b0;
      res_r.bid    <= '0;
      res_r.ask    <= '0;
    end else begin
      if (take_bid) begin
        res_r.bid_p <= 1'b1;
        res_r.bid   <= entry.price;
      end
      if (take_ask) begin
        res_r.ask_p <= 1'b1;
        res_r.ask   <= entry.price;
      end
      if (take_m)    res_r.m_p    <= 1'b1;
      if (take_free) res_r.free_p <= 1'b1;
      if (take_hit)  res_r.hit_p  <= 1'b1;
    end
    if (take_m) begin
      res_r.m_entry <= entry;
      m_idx_r       <= entry_idx;
    end
    if (take_free) free_idx_r <= entry_idx;
    if (take_hit) begin
      hit_idx_r     <= entry_idx;
      hit_arr_r     <= entry.arrival;
      res_r.hit_rem <= entry.remaining;
    end
  end

endmodule

/* sv/price_time_order_matcher.sv */
// Top level: sequencer that walks the order table once per result and drives the book.
//
//  channel  | direction | beat carries
//  in_ch    | in        | func, side, order_id, limit_price, quantity
//  out_ch   | out       | kind, trade and id fields, remaining quantity, best prices, last
//
// A table walk is paced by the single read port of the entry memory, which the scan unit reads
// one slot a cycle; a result costs a walk, a decision and an output step.
// An order or a cancel keeps in_ch.ready low from its beat until its last result is loaded;
// func 3 beats are taken straight from idle, with no walk and no result.
// A stalled out_ch holds the sequencer before it loads the next result.
// Reset (synchronous, rst_n low) empties the book and restarts trade numbering at one.
module price_time_order_matcher import ptom_pkg::*; #(
  parameter int ORDER_SLOTS = DEF_ORDER_SLOTS
) (
  input logic clk,
  input logic rst_n,
  ptom_in_if.sink    in_ch,
  ptom_out_if.source out_ch
);

  localparam int IDX_W = $clog2(ORDER_SLOTS);
  localparam int CNT_W = $clog2(ORDER_SLOTS + 1);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_SCAN   = 2'd1;
  localparam logic [1:0] S_OUT    = 2'd2;
  localparam logic [1:0] S_DECIDE = 2'd3;

  logic [1:0]       state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r;
  logic             eval_r;
  logic [IDX_W-1:0] eval_idx_r;

  logic [1:0]       func_r;
  logic             side_r;
  logic [31:0]      id_r, rem_r;
  logic [19:0]      lim_r;
  logic [TRADE_W-1:0] trades_r;
  logic [31:0]      trade_no_r, arrival_r;

  logic             pend_r, pend_last_r;
  logic [2:0]       pend_kind_r;
  logic [31:0]      pend_tn_r, pend_buy_r, pend_sell_r, pend_qty_r, pend_rem_r;
  logic [19:0]      pend_price_r;

  logic             out_valid_r;
  logic             accept, out_load, scan_clear, scan_done, fill_ok, crosses;
  logic [31:0]      fill_qty, m_rem;

  ptom_entry_t      rd_entry, wr_entry;
  logic             rd_valid;
  logic [IDX_W-1:0] wr_idx;
  ptom_wr_t         wr;
  ptom_scan_t       sres;
  logic [IDX_W-1:0] m_idx, free_idx, hit_idx;

  ptom_book #(.ORDER_SLOTS(ORDER_SLOTS), .IDX_W(IDX_W)) u_book (
    .clk, .rst_n,
    .rd_idx(cnt_r[IDX_W-1:0]), .rd_entry_r(rd_entry), .rd_valid_r(rd_valid),
    .wr_idx, .wr, .wr_entry
  );

  ptom_scan #(.ORDER_SLOTS(ORDER_SLOTS), .IDX_W(IDX_W)) u_scan (
    .clk, .rst_n,
    .clear(scan_clear), .eval(eval_r), .entry(rd_entry), .entry_valid(rd_valid),
    .entry_idx(eval_idx_r), .opp_side(~side_r), .cancel_id(id_r),
    .res_r(sres), .m_idx_r(m_idx), .free_idx_r(free_idx), .hit_idx_r(hit_idx)
  );

  assign in_ch.ready = (state_r == S_IDLE);
  assign accept      = in_ch.valid && in_ch.ready;
  assign out_load    = (state_r == S_OUT) && pend_r && (!out_valid_r || out_ch.ready);
  assign scan_done   = (cnt_r == CNT_W'(ORDER_SLOTS)) && !eval_r;

  assign m_rem    = sres.m_entry.remaining;
  assign fill_qty = (rem_r < m_rem) ? rem_r : m_rem;
  assign crosses  = (func_r == FN_MARKET) ||
                    ((side_r == SIDE_BUY) ? (lim_r >= sres.m_entry.price)
                                          : (lim_r <= sres.m_entry.price));
  assign fill_ok  = (rem_r != 32'd0) && (trades_r < TRADE_W'(MAX_TRADES)) && sres.m_p && crosses;

  // Book writes are made only in the decision cycle, never during a walk.
  always_comb begin
    wr       = '0;
    wr_idx   = m_idx;
    wr_entry = sres.m_entry;
    if (state_r == S_DECIDE) begin
      if (func_r == FN_CANCEL) begin
        wr_idx     = hit_idx;
        wr.vld_we  = sres.hit_p;
        wr.vld_val = 1'b0;
      end else if (fill_ok) begin
        wr.data_we         = 1'b1;
        wr_entry.remaining = m_rem - fill_qty;
        wr.vld_we          = (m_rem == fill_qty);
        wr.vld_val         = 1'b0;
      end else if (rem_r != 32'd0 && func_r == FN_LIMIT && sres.free_p) begin
        wr_idx     = free_idx;
        wr_entry   = '{side: side_r, ident: id_r, price: lim_r, remaining: rem_r,
                       arrival: arrival_r};
        wr.data_we = 1'b1;
        wr.vld_we  = 1'b1;
        wr.vld_val = 1'b1;
      end
    end
  end

  always_comb begin
    state_nxt  = state_r;
    scan_clear = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        if (accept && in_ch.func != FN_NONE) begin
          state_nxt  = S_SCAN;
          scan_clear = 1'b1;
        end
      end
      S_SCAN: begin
        if (scan_done) state_nxt = S_OUT;
      end
      S_OUT: begin
        if (!pend_r) begin
          state_nxt = S_DECIDE;
        end else if (out_load) begin
          state_nxt = pend_last_r ? S_IDLE : S_DECIDE;
        end
      end
      S_DECIDE: begin
        state_nxt  = S_SCAN;
        scan_clear = 1'b1;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      eval_r      <= 1'b0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
      trades_r    <= '0;
      trade_no_r  <= 32'd1;
      arrival_r   <= '0;
    end else begin
      state_r <= state_nxt;
      if (scan_clear) begin
        cnt_r  <= '0;
        eval_r <= 1'b0;
      end else if (state_r == S_SCAN) begin
        eval_r <= (cnt_r != CNT_W'(ORDER_SLOTS));
        if (cnt_r != CNT_W'(ORDER_SLOTS)) cnt_r <= cnt_r + 1'b1;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
        pend_r      <= 1'b0;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
      if (accept) trades_r <= '0;
      if (state_r == S_DECIDE) begin
        pend_r <= 1'b1;
        if (func_r != FN_CANCEL && fill_ok) begin
          trades_r   <= trades_r + 1'b1;
          trade_no_r <= trade_no_r + 32'd1;
        end else if (func_r != FN_CANCEL && wr.vld_we) begin
          arrival_r <= arrival_r + 32'd1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_SCAN) eval_idx_r <= cnt_r[IDX_W-1:0];
    if (accept) begin
      func_r <= in_ch.func;
      side_r <= in_ch.side;
      id_r   <= in_ch.order_id;
      lim_r  <= in_ch.limit_price;
      rem_r  <= in_ch.quantity;
    end
    if (state_r == S_DECIDE) begin
      pend_last_r  <= 1'b1;
      pend_tn_r    <= '0;
      pend_buy_r   <= '0;
      pend_sell_r  <= '0;
      pend_price_r <= '0;
      pend_qty_r   <= '0;
      if (func_r == FN_CANCEL) begin
        pend_kind_r <= sres.hit_p ? KIND_CANCELLED : KIND_NOT_FOUND;
        pend_rem_r  <= sres.hit_p ? sres.hit_rem : 32'd0;
      end else if (fill_ok) begin
        pend_last_r  <= 1'b0;
        pend_kind_r  <= KIND_TRADE;
        pend_tn_r    <= trade_no_r;
        pend_buy_r   <= (side_r == SIDE_BUY) ? id_r : sres.m_entry.ident;
        pend_sell_r  <= (side_r == SIDE_BUY) ? sres.m_entry.ident : id_r;
        pend_price_r <= sres.m_entry.price;
        pend_qty_r   <= fill_qty;
        pend_rem_r   <= rem_r - fill_qty;
        rem_r        <= rem_r - fill_qty;
      end else if (rem_r == 32'd0) begin
        pend_kind_r <= KIND_FILLED;
        pend_rem_r  <= '0;
      end else begin
        pend_kind_r <= wr.vld_we ? KIND_RESTED : KIND_DROPPED;
        pend_rem_r  <= rem_r;
      end
    end
    if (out_load) begin
      out_ch.kind               <= pend_kind_r;
      out_ch.trade_number       <= pend_tn_r;
      out_ch.buy_order_id       <= pend_buy_r;
      out_ch.sell_order_id      <= pend_sell_r;
      out_ch.trade_price        <= pend_price_r;
      out_ch.trade_quantity     <= pend_qty_r;
      out_ch.remaining_quantity <= pend_rem_r;
      out_ch.best_bid           <= sres.bid;
      out_ch.best_ask           <= sres.ask;
      out_ch.bid_present        <= sres.bid_p;
      out_ch.ask_present        <= sres.ask_p;
      out_ch.last               <= pend_last_r;
    end
  end

  assign out_ch.valid = out_valid_r;

  a_trades_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    trades_r <= TRADE_W'(MAX_TRADES))
    else $error("trade count beyond limit");

  a_idle_no_pending: assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> !pend_r)
    else $error("new order taken while a result is pending");

  a_last_to_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_load && pend_last_r) |=> (state_r == S_IDLE))
    else $error("final result did not return to idle");

  a_write_in_decide: assert property (@(posedge clk) disable iff (!rst_n)
    (wr.data_we || wr.vld_we) |-> (state_r == S_DECIDE))
    else $error("book written outside decision cycle");

endmodule

/* dv/price_time_order_matcher_tb.sv */
// Self-checking testbench of the price-time order matcher: directed rows, then random order flow.
module price_time_order_matcher_tb;
  import ptom_pkg::*;

  localparam int SLOTS = DEF_ORDER_SLOTS;
  localparam int IDLE_LIMIT = 20000;
  localparam int RANDOM_ITEMS = 350;

  typedef struct {
    logic [1:0]  func;
    logic        side;
    logic [31:0] order_id;
    logic [19:0] limit_price;
    logic [31:0] quantity;
  } order_t;

  typedef struct {
    logic [2:0]  kind;
    logic [31:0] trade_number;
    logic [31:0] buy_order_id;
    logic [31:0] sell_order_id;
    logic [19:0] trade_price;
    logic [31:0] trade_quantity;
    logic [31:0] remaining_quantity;
    logic [19:0] best_bid;
    logic [19:0] best_ask;
    logic        bid_present;
    logic        ask_present;
    logic        last;
  } report_t;

  typedef struct {
    order_t  o;
    bit      typed;
    bit      silent;
    report_t want;
  } row_t;

  logic clk;
  logic rst_n;
  ptom_in_if  in_ch ();
  ptom_out_if out_ch ();

  price_time_order_matcher dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // Shadow copy of the order book.
  logic        book_live [SLOTS] = '{default: 1'b0};
  logic        book_side [SLOTS];
  logic [31:0] book_id   [SLOTS];
  logic [19:0] book_px   [SLOTS];
  logic [31:0] book_qty  [SLOTS];
  logic [31:0] book_seq  [SLOTS];
  logic [31:0] seq_counter = 32'd0;
  logic [31:0] trade_counter = 32'd1;

  report_t fresh_reports [$];
  report_t awaited_reports [$];
  row_t    directed_rows [$];
  int      errors = 0;
  int      orders_taken = 0;
  bit      stimulus_done = 0;
  bit      accept_seen;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic void side_best(input logic sd, output logic found, output logic [19:0] px);
    found = 1'b0;
    px = '0;
    for (int i = 0; i < SLOTS; i++) begin
      if (book_live[i] && book_side[i] == sd) begin
        if (!found || (sd == SIDE_BUY ? book_px[i] > px : book_px[i] < px)) px = book_px[i];
        found = 1'b1;
      end
    end
  endfunction

  function automatic int best_slot(logic sd);
    int pick;
    pick = -1;
    for (int i = 0; i < SLOTS; i++) begin
      if (!book_live[i] || book_side[i] != sd) continue;
      if (pick < 0) pick = i;
      else if (book_px[i] != book_px[pick]) begin
        if (sd == SIDE_BUY ? book_px[i] > book_px[pick] : book_px[i] < book_px[pick]) pick = i;
      end else if (book_seq[i] < book_seq[pick]) pick = i;
    end
    return pick;
  endfunction

  function automatic void add_report(logic [2:0] kind, logic [31:0] tn, logic [31:0] buy,
                                     logic [31:0] sell, logic [19:0] px, logic [31:0] qty,
                                     logic [31:0] rem, logic last);
    report_t r;
    r.kind = kind;
    r.trade_number = tn;
    r.buy_order_id = buy;
    r.sell_order_id = sell;
    r.trade_price = px;
    r.trade_quantity = qty;
    r.remaining_quantity = rem;
    side_best(SIDE_BUY, r.bid_present, r.best_bid);
    side_best(SIDE_SELL, r.ask_present, r.best_ask);
    r.last = last;
    fresh_reports = {fresh_reports, r};
  endfunction

  // Applies one order to the shadow book and leaves its reports in fresh_reports.
  function automatic void match_order(order_t o);
    logic [31:0] rem, m;
    int hit, s, n, fr;
    fresh_reports.delete();
    rem = o.quantity;
    n = 0;
    if (o.func == FN_NONE) return;
    if (o.func == FN_CANCEL) begin
      hit = -1;
      for (int i = 0; i < SLOTS; i++)
        if (book_live[i] && book_id[i] == o.order_id && (hit < 0 || book_seq[i] < book_seq[hit]))
          hit = i;
      if (hit >= 0) begin
        book_live[hit] = 1'b0;
        add_report(KIND_CANCELLED, 0, 0, 0, 0, 0, book_qty[hit], 1'b1);
      end else add_report(KIND_NOT_FOUND, 0, 0, 0, 0, 0, 0, 1'b1);
      return;
    end
    while (rem != 0 && n < MAX_TRADES) begin
      s = best_slot(~o.side);
      if (s < 0) break;
      if (o.func == FN_LIMIT) begin
        if (o.side == SIDE_BUY && o.limit_price < book_px[s]) break;
        if (o.side == SIDE_SELL && o.limit_price > book_px[s]) break;
      end
      m = rem < book_qty[s] ? rem : book_qty[s];
      rem -= m;
      book_qty[s] -= m;
      if (book_qty[s] == 0) book_live[s] = 1'b0;
      add_report(KIND_TRADE, trade_counter, o.side == SIDE_BUY ? o.order_id : book_id[s],
                 o.side == SIDE_BUY ? book_id[s] : o.order_id, book_px[s], m, rem, 1'b0);
      trade_counter += 1;
      n++;
    end
    if (rem == 0) add_report(KIND_FILLED, 0, 0, 0, 0, 0, 0, 1'b1);
    else if (o.func == FN_MARKET) add_report(KIND_DROPPED, 0, 0, 0, 0, 0, rem, 1'b1);
    else begin
      fr = -1;
      for (int i = 0; i < SLOTS; i++)
        if (fr < 0 && !book_live[i]) fr = i;
      if (fr < 0) add_report(KIND_DROPPED, 0, 0, 0, 0, 0, rem, 1'b1);
      else begin
        book_live[fr] = 1'b1;
        book_side[fr] = o.side;
        book_id[fr] = o.order_id;
        book_px[fr] = o.limit_price;
        book_qty[fr] = rem;
        book_seq[fr] = seq_counter;
        seq_counter += 1;
        add_report(KIND_RESTED, 0, 0, 0, 0, 0, rem, 1'b1);
      end
    end
  endfunction

  function automatic int resting_count();
    int c;
    c = 0;
    for (int i = 0; i < SLOTS; i++) c += book_live[i];
    return c;
  endfunction

  function automatic order_t mk(logic [1:0] f, logic sd, logic [31:0] id, logic [19:0] px,
                                logic [31:0] q);
    order_t o;
    o.func = f;
    o.side = sd;
    o.order_id = id;
    o.limit_price = px;
    o.quantity = q;
    return o;
  endfunction

  function automatic report_t status_only(logic [2:0] kind, logic [31:0] rem);
    report_t r;
    r = '{kind: kind, remaining_quantity: rem, last: 1'b1, default: '0};
    return r;
  endfunction

  function automatic void row(order_t o);
    row_t r;
    r.o = o;
    r.typed = 0;
    r.silent = 0;
    directed_rows = {directed_rows, r};
  endfunction

  function automatic void typed_row(order_t o, bit silent, report_t want);
    row_t r;
    r.o = o;
    r.typed = 1;
    r.silent = silent;
    r.want = want;
    directed_rows = {directed_rows, r};
  endfunction

  function automatic logic [31:0] pick_qty();
    int c;
    c = $urandom_range(0, 99);
    if (c < 3) return 32'd0;
    if (c < 8) return $urandom;
    return $urandom_range(1, 40);
  endfunction

  function automatic logic [31:0] pick_id();
    return ($urandom_range(0, 19) == 0) ? $urandom : 32'($urandom_range(0, 80));
  endfunction

  // Early items build a resting book that does not cross; later ones trade around the spread.
  function automatic order_t random_order(int k);
    order_t o;
    int c;
    logic sd;
    c = $urandom_range(0, 99);
    sd = 1'($urandom_range(0, 1));
    if (k < 110) begin
      if (c < 88) o = mk(FN_LIMIT, sd, pick_id(),
                         sd == SIDE_BUY ? 20'(1000 + $urandom_range(0, 20))
                                        : 20'(1030 + $urandom_range(0, 20)), pick_qty());
      else o = mk(FN_CANCEL, sd, pick_id(), 20'($urandom), $urandom);
    end else begin
      if (c < 55) o = mk(FN_LIMIT, sd, pick_id(), 20'(1000 + $urandom_range(0, 50)), pick_qty());
      else if (c < 68) o = mk(FN_MARKET, sd, pick_id(), 20'($urandom), pick_qty());
      else if (c < 88) o = mk(FN_CANCEL, sd, pick_id(), 20'($urandom), $urandom);
      else if (c < 91) o = mk(FN_NONE, sd, $urandom, 20'($urandom), $urandom);
      else if (c < 95 && resting_count() > 40) o = mk(FN_MARKET, sd, pick_id(), 0, $urandom);
      else o = mk(FN_LIMIT, sd, $urandom, 20'($urandom), $urandom);
    end
    return o;
  endfunction

  function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      errors++;
    end
  endfunction

  task automatic offer(order_t o, row_t r, bit directed);
    int gap;
    gap = ($urandom_range(0, 9) < 6) ? 0 :
          ($urandom_range(0, 19) == 0) ? $urandom_range(30, 150) : $urandom_range(1, 4);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.func <= o.func;
    in_ch.side <= o.side;
    in_ch.order_id <= o.order_id;
    in_ch.limit_price <= o.limit_price;
    in_ch.quantity <= o.quantity;
    do @(posedge clk); while (!(in_ch.valid && in_ch.ready));
    match_order(o);
    if (directed && r.typed) begin
      if (!r.silent) awaited_reports = {awaited_reports, r.want};
    end else
      foreach (fresh_reports[i]) awaited_reports = {awaited_reports, fresh_reports[i]};
    orders_taken++;
  endtask

  // Sender.
  initial begin
    row_t none;
    in_ch.valid <= 1'b0;
    in_ch.func <= FN_LIMIT;
    in_ch.side <= SIDE_BUY;
    in_ch.order_id <= '0;
    in_ch.limit_price <= '0;
    in_ch.quantity <= '0;
    rst_n <= 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    typed_row(mk(FN_CANCEL, SIDE_BUY, 32'd5, 0, 0), 0, status_only(KIND_NOT_FOUND, 0));
    typed_row(mk(FN_NONE, SIDE_SELL, 32'hFFFF_FFFF, 20'hFFFFF, 32'hFFFF_FFFF), 1, none.want);
    typed_row(mk(FN_LIMIT, SIDE_BUY, 32'd1, 20'd50, 0), 0, status_only(KIND_FILLED, 0));
    typed_row(mk(FN_MARKET, SIDE_BUY, 32'd2, 0, 32'd100), 0, status_only(KIND_DROPPED, 100));
    row(mk(FN_LIMIT, SIDE_BUY, 32'hFFFF_FFFF, 20'hFFFFF, 32'hFFFF_FFFF));
    row(mk(FN_LIMIT, SIDE_SELL, 32'd0, 20'd0, 32'd10));
    row(mk(FN_LIMIT, SIDE_SELL, 32'd7, 20'd0, 32'hFFFF_FFFF));
    row(mk(FN_MARKET, SIDE_BUY, 32'd3, 20'hFFFFF, 32'd3));
    row(mk(FN_LIMIT, SIDE_SELL, 32'd7, 20'd500, 32'd4));
    row(mk(FN_CANCEL, SIDE_SELL, 32'd7, 0, 0));
    row(mk(FN_CANCEL, SIDE_BUY, 32'd7, 0, 0));
    row(mk(FN_CANCEL, SIDE_BUY, 32'd7, 0, 0));
    // Equal prices: the earlier arrival must trade first.
    row(mk(FN_LIMIT, SIDE_SELL, 32'd20, 20'd300, 32'd5));
    row(mk(FN_LIMIT, SIDE_SELL, 32'd21, 20'd300, 32'd5));
    row(mk(FN_LIMIT, SIDE_SELL, 32'd22, 20'd299, 32'd5));
    row(mk(FN_LIMIT, SIDE_BUY, 32'd23, 20'd300, 32'd12));
    row(mk(FN_LIMIT, SIDE_BUY, 32'd24, 20'd100, 32'd6));
    row(mk(FN_LIMIT, SIDE_BUY, 32'd25, 20'd100, 32'd6));
    row(mk(FN_MARKET, SIDE_SELL, 32'd26, 0, 32'd8));
    row(mk(FN_LIMIT, SIDE_SELL, 32'd27, 20'd100, 32'd20));
    row(mk(FN_LIMIT, SIDE_BUY, 32'd28, 20'd99, 32'd1));

    foreach (directed_rows[i]) offer(directed_rows[i].o, directed_rows[i], 1);
    for (int k = 0; k < RANDOM_ITEMS; k++) offer(random_order(k), none, 0);
    in_ch.valid <= 1'b0;
    stimulus_done = 1;
  end

  // Receiver, with one long hold-off so that the block backs up into its input.
  initial begin
    int hold;
    bit pressed;
    report_t w;
    hold = 0;
    pressed = 0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (out_ch.valid && out_ch.ready) begin
        if (awaited_reports.size() == 0) begin
          $error("result beat with nothing expected, kind %0d", out_ch.kind);
          errors++;
        end else begin
          w = awaited_reports.pop_front();
          check_field("kind", w.kind, out_ch.kind);
          check_field("trade_number", w.trade_number, out_ch.trade_number);
          check_field("buy_order_id", w.buy_order_id, out_ch.buy_order_id);
          check_field("sell_order_id", w.sell_order_id, out_ch.sell_order_id);
          check_field("trade_price", w.trade_price, out_ch.trade_price);
          check_field("trade_quantity", w.trade_quantity, out_ch.trade_quantity);
          check_field("remaining_quantity", w.remaining_quantity, out_ch.remaining_quantity);
          check_field("best_bid", w.best_bid, out_ch.best_bid);
          check_field("best_ask", w.best_ask, out_ch.best_ask);
          check_field("bid_present", w.bid_present, out_ch.bid_present);
          check_field("ask_present", w.ask_present, out_ch.ask_present);
          check_field("last", w.last, out_ch.last);
        end
      end
      if (!pressed && orders_taken >= 160) begin
        pressed = 1;
        hold = 3000;
      end else if (hold == 0) begin
        case ($urandom_range(0, 39))
          0: hold = $urandom_range(40, 200);
          1, 2, 3, 4: hold = $urandom_range(1, 4);
          default: hold = 0;
        endcase
      end
      if (hold > 0) begin
        out_ch.ready <= 1'b0;
        hold--;
      end else out_ch.ready <= 1'b1;
    end
  end

  // Watchdog on cycles in which neither channel moves a beat.
  initial begin
    int idle;
    idle = 0;
    forever begin
      @(posedge clk);
      accept_seen = (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready);
      idle = accept_seen ? 0 : idle + 1;
      if (idle >= IDLE_LIMIT) begin
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  // End of run.
  initial begin
    wait (stimulus_done);
    while (awaited_reports.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (errors == 0 && awaited_reports.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
